@@ sv/sra_pkg.sv @@
`timescale 1ns / 1ps
package sra_pkg;

    // Frame geometry
    localparam int ADDR_W    = 12;
    localparam int HDR_W     = 16;
    localparam int DATA_W    = 32;
    localparam int BIT_W     = 6;
    localparam int HP_W      = 8;
    localparam int HDR_BITS  = 16;
    localparam int DATA_BITS = 32;

    localparam logic [HP_W-1:0] HP_RESET = 8'd5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_GAP,
        PH_DATA
    } t_phase;

    // One tick as classified by the front end
    typedef struct packed {
        logic              start_req;
        logic              mode;
        logic              channel;
        logic [HDR_W-1:0]  header;
        logic [DATA_W-1:0] data_init;
        logic              sdata_in;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Pin levels after one tick
    typedef struct packed {
        logic              csn_first;
        logic              csn_second;
        logic              sclk_out;
        logic              sdata_out;
        logic              sdata_drive;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
    } t_res;

endpackage

@@ sv/sra_in_if.sv @@
`timescale 1ns / 1ps
interface sra_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic        mode;
    logic        channel;
    logic [11:0] reg_addr;
    logic [31:0] write_data;
    logic        sdata_in;

    modport source (
        output valid, start_req, mode, channel, reg_addr, write_data, sdata_in,
        input  ready
    );
    modport sink (
        input  valid, start_req, mode, channel, reg_addr, write_data, sdata_in,
        output ready
    );
endinterface

@@ sv/sra_out_if.sv @@
`timescale 1ns / 1ps
interface sra_out_if;
    logic        valid;
    logic        ready;
    logic        csn_first;
    logic        csn_second;
    logic        sclk_out;
    logic        sdata_out;
    logic        sdata_drive;
    logic        busy_res;
    logic        done_res;
    logic [31:0] read_data;

    modport source (
        output valid, csn_first, csn_second, sclk_out, sdata_out, sdata_drive,
               busy_res, done_res, read_data,
        input  ready
    );
    modport sink (
        input  valid, csn_first, csn_second, sclk_out, sdata_out, sdata_drive,
               busy_res, done_res, read_data,
        output ready
    );
endinterface

@@ sv/sra_front.sv @@
`timescale 1ns / 1ps
module sra_front (
    sra_in_if.sink          i_req,
    input  sra_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output sra_pkg::t_item   o_item
);

    // Accept whenever the queue has room
    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && !i_q_stat.full;

    // Pre-build the header word and the initial data shift value
    always_comb begin
        o_item.start_req = i_req.start_req;
        o_item.mode      = i_req.mode;
        o_item.channel   = i_req.channel;
        o_item.header    = {i_req.reg_addr, i_req.mode, 3'b000};
        o_item.data_init = i_req.mode ? '0 : i_req.write_data;
        o_item.sdata_in  = i_req.sdata_in;
    end

endmodule

@@ sv/sra_queue.sv @@
`timescale 1ns / 1ps
module sra_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sra_pkg::t_item   i_item,
    input  logic             i_pop,
    output sra_pkg::t_item   o_head,
    output sra_pkg::t_q_stat o_q_stat
);

    sra_pkg::t_item                   r_mem [sra_pkg::QUEUE_DEPTH];
    logic [sra_pkg::QPTR_W-1:0]       r_wptr;
    logic [sra_pkg::QPTR_W-1:0]       r_rptr;
    logic [sra_pkg::QCNT_W-1:0]       r_count;

    assign o_q_stat.full  = (r_count == sra_pkg::QCNT_W'(sra_pkg::QUEUE_DEPTH));
    assign o_q_stat.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/sra_back.sv @@
`timescale 1ns / 1ps
module sra_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sra_pkg::HP_W-1:0]   i_cfg_wdata,
    input  sra_pkg::t_item             i_item,
    input  sra_pkg::t_q_stat           i_q_stat,
    output logic                       o_pop,
    sra_out_if.source                  o_res
);

    // Serializer state
    sra_pkg::t_phase                 r_phase, n_phase;
    logic [sra_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic [sra_pkg::HP_W-1:0]        r_tick, n_tick;
    logic [sra_pkg::HDR_W-1:0]       r_hdr, n_hdr;
    logic [sra_pkg::DATA_W-1:0]      r_data, n_data;
    logic [sra_pkg::DATA_W-1:0]      r_accum, n_accum;
    logic                            r_chan, n_chan;
    logic                            r_mode, n_mode;
    logic                            r_sclk, n_sclk;
    logic                            n_done;
    logic [sra_pkg::HP_W-1:0]        r_half_period;

    // Output register
    logic                            r_out_valid;
    sra_pkg::t_res                   r_res, n_res;

    logic                            w_fire;
    logic [sra_pkg::HP_W-1:0]        w_hp;
    logic [sra_pkg::HP_W:0]          w_tick_inc;
    logic [sra_pkg::BIT_W-1:0]       w_bit_inc;

    // One tick is executed when a queued item exists and the output slot frees
    assign w_fire = !i_q_stat.empty && (!r_out_valid || o_res.ready);
    assign o_pop  = w_fire;

    assign w_hp       = (r_half_period == '0) ? sra_pkg::HP_W'(1) : r_half_period;
    assign w_tick_inc = {1'b0, r_tick} + 1'b1;
    assign w_bit_inc  = r_bit + 1'b1;

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_hdr   = r_hdr;
        n_data  = r_data;
        n_accum = r_accum;
        n_chan  = r_chan;
        n_mode  = r_mode;
        n_sclk  = r_sclk;
        n_done  = 1'b0;
        if (w_fire) begin
            unique case (r_phase) inside
                sra_pkg::PH_HEADER, sra_pkg::PH_GAP, sra_pkg::PH_DATA: begin
                    if (w_tick_inc < {1'b0, w_hp}) begin
                        n_tick = w_tick_inc[sra_pkg::HP_W-1:0];
                    end else begin
                        n_tick = '0;
                        if (r_phase == sra_pkg::PH_GAP) begin
                            // first data bit starts with clock high
                            n_phase = sra_pkg::PH_DATA;
                            n_bit   = '0;
                            n_sclk  = 1'b1;
                            if (r_mode) begin
                                n_data = {r_data[sra_pkg::DATA_W-2:0], i_item.sdata_in};
                            end
                        end else if (r_sclk) begin
                            n_sclk = 1'b0;
                        end else if (r_phase == sra_pkg::PH_HEADER) begin
                            n_hdr = {r_hdr[sra_pkg::HDR_W-2:0], 1'b0};
                            n_bit = w_bit_inc;
                            if (w_bit_inc >= sra_pkg::BIT_W'(sra_pkg::HDR_BITS)) begin
                                n_phase = sra_pkg::PH_GAP;
                                n_bit   = '0;
                            end else begin
                                n_sclk = 1'b1;
                            end
                        end else begin
                            if (!r_mode) begin
                                n_data = {r_data[sra_pkg::DATA_W-2:0], 1'b0};
                            end
                            n_bit = w_bit_inc;
                            if (w_bit_inc >= sra_pkg::BIT_W'(sra_pkg::DATA_BITS)) begin
                                n_phase = sra_pkg::PH_IDLE;
                                n_bit   = '0;
                                n_done  = 1'b1;
                                if (r_mode) begin
                                    n_accum = r_data;
                                end
                            end else begin
                                n_sclk = 1'b1;
                                if (r_mode) begin
                                    n_data = {r_data[sra_pkg::DATA_W-2:0], i_item.sdata_in};
                                end
                            end
                        end
                    end
                end
                sra_pkg::PH_IDLE: begin
                    if (i_item.start_req) begin
                        n_chan  = i_item.channel;
                        n_mode  = i_item.mode;
                        n_hdr   = i_item.header;
                        n_data  = i_item.data_init;
                        n_bit   = '0;
                        n_tick  = '0;
                        n_sclk  = 1'b1;
                        n_phase = sra_pkg::PH_HEADER;
                    end
                end
                default: n_phase = sra_pkg::PH_IDLE;
            endcase
        end
    end

    // Pin levels after the tick
    always_comb begin
        n_res.busy_res    = (n_phase != sra_pkg::PH_IDLE);
        n_res.csn_first   = !(n_res.busy_res && !n_chan);
        n_res.csn_second  = !(n_res.busy_res && n_chan);
        n_res.sclk_out    = n_res.busy_res && n_sclk;
        n_res.done_res    = n_done;
        n_res.read_data   = n_accum;
        unique case (n_phase)
            sra_pkg::PH_HEADER: begin
                n_res.sdata_drive = 1'b1;
                n_res.sdata_out   = n_hdr[sra_pkg::HDR_W-1];
            end
            sra_pkg::PH_GAP: begin
                n_res.sdata_drive = !n_mode;
                n_res.sdata_out   = 1'b0;
            end
            sra_pkg::PH_DATA: begin
                n_res.sdata_drive = !n_mode;
                n_res.sdata_out   = !n_mode && n_data[sra_pkg::DATA_W-1];
            end
            default: begin
                n_res.sdata_drive = 1'b0;
                n_res.sdata_out   = 1'b0;
            end
        endcase
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= sra_pkg::PH_IDLE;
            r_bit         <= '0;
            r_tick        <= '0;
            r_hdr         <= '0;
            r_data        <= '0;
            r_accum       <= '0;
            r_chan        <= 1'b0;
            r_mode        <= 1'b0;
            r_sclk        <= 1'b0;
            r_half_period <= sra_pkg::HP_RESET;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_hdr   <= n_hdr;
            r_data  <= n_data;
            r_accum <= n_accum;
            r_chan  <= n_chan;
            r_mode  <= n_mode;
            r_sclk  <= n_sclk;
            if (i_cfg_we) begin
                r_half_period <= i_cfg_wdata;
            end
        end
    end

    // Output slot: filled on a tick, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.csn_first   = r_res.csn_first;
    assign o_res.csn_second  = r_res.csn_second;
    assign o_res.sclk_out    = r_res.sclk_out;
    assign o_res.sdata_out   = r_res.sdata_out;
    assign o_res.sdata_drive = r_res.sdata_drive;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.read_data   = r_res.read_data;

    // Frame end only comes out of the data phase
    a_done_from_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> (r_phase == sra_pkg::PH_DATA))
        else $error("frame end outside data phase");

    // Clock stays low through the gap
    a_gap_clock_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sra_pkg::PH_GAP) |-> !r_sclk)
        else $error("serial clock high in gap");

    // Bit counter never reaches the data length while held
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < sra_pkg::BIT_W'(sra_pkg::DATA_BITS))
        else $error("bit counter out of range");

    // A tick is never executed from an empty queue, and a stalled slot is kept
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!i_q_stat.empty && (!r_out_valid || o_res.ready)))
        else $error("pop without item or free slot");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_phase) && $stable(r_tick))
        else $error("serializer advanced without a tick");

endmodule

@@ sv/spi_register_access_master.sv @@
`timescale 1ns / 1ps
// Three-wire SPI register master for a two-channel RF front end.
// Input channel i_req carries one transaction per serializer tick: start_req,
// mode, channel, reg_addr, write_data and the sampled data pin sdata_in.
// Output channel o_res returns exactly one transaction per input transaction:
// both chip selects, sclk, data out, drive enable, busy, done and read_data.
// A start in idle sends a 16-bit header (address, mode, three zeros), one
// low half-period gap, then 32 data bits out (write) or in (read), MSB first.
// The user must write half_period through i_cfg_we / i_cfg_wdata only while
// no transaction is in flight; the block does not enforce this. A value of 0
// acts as 1. Reset value is 5. Throughput: one transaction per cycle, set by
// the tick step in the back end, while the queue holds a transaction and the
// output slot is free or being taken. An accepted transaction is written into
// the 4-entry command queue at its accept edge, and its tick runs from the
// queue head into the output register once the output slot frees.
// When o_res stalls, the result waits in the output register and the queue
// keeps taking input until it holds 4 transactions; then i_req.ready drops.
// Synchronous reset returns the serializer to idle (clock low, read data zero)
// and empties the queue and output slot; the output register is not reset.
module spi_register_access_master (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [sra_pkg::HP_W-1:0] i_cfg_wdata,
    sra_in_if.sink                   i_req,
    sra_out_if.source                o_res
);

    logic             w_push;
    logic             w_pop;
    sra_pkg::t_item   w_item;
    sra_pkg::t_item   w_head;
    sra_pkg::t_q_stat w_q_stat;

    // Accept and classify
    sra_front u_front (
        .i_req    (i_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_item)
    );

    // Command queue
    sra_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_q_stat (w_q_stat)
    );

    // Serializer and output register
    sra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule
